// ===== rtl/core/gptc_pkg.sv =====
// ----------------------------------------------------------------------------
// gptc_pkg
// Shared widths, register indexes, reset values and control structs of the
// glow plug timer controller.
// ----------------------------------------------------------------------------
package gptc_pkg;

  // field widths
  localparam int TEMP_W     = 9;
  localparam int RPM_W      = 13;
  localparam int TMIN_W     = 7;
  localparam int MAXS_W     = 8;
  localparam int MULT_W     = 4;
  localparam int TIME_W     = 16;
  localparam int CNT_W      = TIME_W + 1;
  localparam int DIFF_W     = 9;
  localparam int PROD_W     = 17;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 13;

  // serial divider: one quotient bit per step
  localparam int DIV_STEPS  = PROD_W;
  localparam int DIV_CNT_W  = $clog2(DIV_STEPS + 1);

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_GLOW_MIN_TEMP    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_GLOW_SECONDS = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_COLD_ENGINE_TEMP = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_RUNNING_RPM  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_AFTER_START_MULT = 3'd4;

  // register reset values
  localparam logic [TMIN_W-1:0]        RST_GLOW_MIN_TEMP    = 7'd60;
  localparam logic [MAXS_W-1:0]        RST_MAX_GLOW_SECONDS = 8'd30;
  localparam logic signed [TEMP_W-1:0] RST_COLD_ENGINE_TEMP = 9'sd50;
  localparam logic [RPM_W-1:0]         RST_MIN_RUNNING_RPM  = 13'd500;
  localparam logic [MULT_W-1:0]        RST_AFTER_START_MULT = 4'd2;

  // lamp time: divide by 8 at or above this temperature, else by 3
  localparam logic signed [TEMP_W-1:0] LAMP_SHORT_TEMP = 9'sd5;
  localparam int                       LAMP_DIV8_SHIFT = 3;

  // x / 3 == (x * RECIP3) >> RECIP3_SHIFT, exact for any 16 bit x
  localparam int                RECIP3_SHIFT = 17;
  localparam int                RECIP3_PW    = TIME_W + RECIP3_SHIFT;
  localparam logic [TIME_W:0]   RECIP3       = 17'd43691;

  // after-start product width
  localparam int RUN_PW = TIME_W + MULT_W;

  // controller to datapath commands
  typedef struct packed {
    logic load;
    logic eval;
    logic div_start;
    logic time_clear;
    logic time_load;
    logic apply;
    logic tick;
    logic out_load;
  } cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic need_heat;
    logic zero_time;
    logic div_done;
    logic out_free;
  } sts_t;

endpackage

// ===== rtl/core/gptc_if.sv =====
// ----------------------------------------------------------------------------
// gptc_if
// Valid/ready channels of the glow plug timer controller: request items in,
// drive results out.
// ----------------------------------------------------------------------------
interface gptc_req_if;
  logic                                 valid;
  logic                                 ready;
  logic                                 req_type;
  logic signed [gptc_pkg::TEMP_W-1:0]   coolant_temp;
  logic [gptc_pkg::RPM_W-1:0]           engine_rpm;
  logic                                 second_tick;

  modport source (output valid, req_type, coolant_temp, engine_rpm, second_tick,
                  input ready);
  modport sink   (input valid, req_type, coolant_temp, engine_rpm, second_tick,
                  output ready);
endinterface

interface gptc_res_if;
  logic valid;
  logic ready;
  logic plug_on;
  logic lamp_on;
  logic heating;

  modport source (output valid, plug_on, lamp_on, heating, input ready);
  modport sink   (input valid, plug_on, lamp_on, heating, output ready);
endinterface

// ===== rtl/core/gptc_div.sv =====
// ----------------------------------------------------------------------------
// gptc_div
// Restoring serial divider, one quotient bit per cycle, for the heating time
// max_glow_seconds * (tmin - temp) / tmin.
// ----------------------------------------------------------------------------
module gptc_div (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [gptc_pkg::PROD_W-1:0]   dividend,
  input  logic [gptc_pkg::TMIN_W-1:0]   divisor,
  output logic                          done,
  output logic [gptc_pkg::PROD_W-1:0]   quotient
);
  import gptc_pkg::*;

  logic                  busy;
  logic [DIV_CNT_W-1:0]  cnt;
  logic [TMIN_W-1:0]     rem;
  logic [TMIN_W-1:0]     dvs;
  logic [PROD_W-1:0]     quo;
  logic [TMIN_W:0]       trial;
  logic [TMIN_W:0]       trial_sub;
  logic                  fits;

  // one restoring step
  always_comb begin
    trial     = {rem, quo[PROD_W-1]};
    trial_sub = trial - {1'b0, dvs};
    fits      = (trial >= {1'b0, dvs});
  end

  // control of the iteration
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= DIV_CNT_W'(DIV_STEPS);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == DIV_CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // partial remainder and quotient shift register
  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      dvs <= divisor;
      quo <= dividend;
    end else if (busy) begin
      rem <= fits ? trial_sub[TMIN_W-1:0] : trial[TMIN_W-1:0];
      quo <= {quo[PROD_W-2:0], fits};
    end
  end

  assign quotient = quo;

  a_done_after_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy))
    else $error("divider done without a running division");

  a_no_restart: assert property (@(posedge clk) disable iff (rst)
    start |-> !busy)
    else $error("divider started while busy");

endmodule

// ===== rtl/core/gptc_dp.sv =====
// ----------------------------------------------------------------------------
// gptc_dp
// Datapath: configuration registers, latched request, heating time
// arithmetic, the two countdown timers, drive flags and the result register.
// ----------------------------------------------------------------------------
module gptc_dp (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_wr_en,
  input  logic [gptc_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [gptc_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  logic                                req_type,
  input  logic signed [gptc_pkg::TEMP_W-1:0]  coolant_temp,
  input  logic [gptc_pkg::RPM_W-1:0]          engine_rpm,
  input  logic                                second_tick,
  output logic                                res_valid,
  input  logic                                res_ready,
  output logic                                plug_on,
  output logic                                lamp_on,
  output logic                                heating,
  input  gptc_pkg::cmd_t                      cmd,
  output gptc_pkg::sts_t                      sts
);
  import gptc_pkg::*;

  // configuration
  logic [TMIN_W-1:0]         glow_min_temp;
  logic [MAXS_W-1:0]         max_glow_seconds;
  logic signed [TEMP_W-1:0]  cold_engine_temp;
  logic [RPM_W-1:0]          min_running_rpm;
  logic [MULT_W-1:0]         after_start_multiplier;

  // latched request
  logic                      item_run;
  logic signed [TEMP_W-1:0]  item_temp;
  logic [RPM_W-1:0]          item_rpm;
  logic                      item_tick;

  // controller state
  logic signed [CNT_W-1:0]   heat_left;
  logic signed [CNT_W-1:0]   lamp_left;
  logic                      warm;
  logic                      plug_drv;
  logic                      lamp_drv;
  logic [TIME_W-1:0]         htime;

  // arithmetic
  logic signed [TEMP_W:0]    temp_ext;
  logic signed [TEMP_W:0]    tmin_ext;
  logic signed [TEMP_W:0]    diff_wide;
  logic [DIFF_W-1:0]         diff;
  logic [PROD_W-1:0]         prod;
  logic                      warm_new;
  logic                      div_done;
  logic [PROD_W-1:0]         quo;
  logic [RUN_PW-1:0]         run_prod;
  logic [TIME_W-1:0]         run_sat;
  logic [RECIP3_PW-1:0]      lamp3_prod;
  logic [TIME_W-1:0]         lamp_time;
  logic                      htime_nz;

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      glow_min_temp          <= RST_GLOW_MIN_TEMP;
      max_glow_seconds       <= RST_MAX_GLOW_SECONDS;
      cold_engine_temp       <= RST_COLD_ENGINE_TEMP;
      min_running_rpm        <= RST_MIN_RUNNING_RPM;
      after_start_multiplier <= RST_AFTER_START_MULT;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        CFG_GLOW_MIN_TEMP:    glow_min_temp          <= cfg_data[TMIN_W-1:0];
        CFG_MAX_GLOW_SECONDS: max_glow_seconds       <= cfg_data[MAXS_W-1:0];
        CFG_COLD_ENGINE_TEMP: cold_engine_temp       <= $signed(cfg_data[TEMP_W-1:0]);
        CFG_MIN_RUNNING_RPM:  min_running_rpm        <= cfg_data[RPM_W-1:0];
        CFG_AFTER_START_MULT: after_start_multiplier <= cfg_data[MULT_W-1:0];
        default: ;
      endcase
    end
  end

  // request latch
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      item_run  <= req_type;
      item_temp <= coolant_temp;
      item_rpm  <= engine_rpm;
      item_tick <= second_tick;
    end
  end

  // heating time operands and decisions
  always_comb begin
    temp_ext  = {item_temp[TEMP_W-1], item_temp};
    tmin_ext  = $signed({3'b000, glow_min_temp});
    diff_wide = tmin_ext - temp_ext;
    diff      = diff_wide[DIFF_W-1:0];
    prod      = PROD_W'(max_glow_seconds) * PROD_W'(diff);
    warm_new  = warm | (item_run & (item_temp > cold_engine_temp));
    sts.need_heat = !item_run || (!warm_new && (item_rpm > min_running_rpm));
    sts.zero_time = (glow_min_temp == '0) || (temp_ext >= tmin_ext);
    sts.div_done  = div_done;
    sts.out_free  = !res_valid || res_ready;
  end

  gptc_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (prod),
    .divisor  (glow_min_temp),
    .done     (div_done),
    .quotient (quo)
  );

  // saturated heating time
  always_ff @(posedge clk) begin
    if (cmd.time_clear) begin
      htime <= '0;
    end else if (cmd.time_load) begin
      htime <= quo[PROD_W-1] ? '1 : quo[TIME_W-1:0];
    end
  end

  // after-start scaling and lamp time
  always_comb begin
    htime_nz   = |htime;
    run_prod   = RUN_PW'(htime) * RUN_PW'(after_start_multiplier);
    run_sat    = (|run_prod[RUN_PW-1:TIME_W]) ? '1 : run_prod[TIME_W-1:0];
    lamp3_prod = RECIP3_PW'(htime) * RECIP3_PW'(RECIP3);
    if (item_temp >= LAMP_SHORT_TEMP) begin
      lamp_time = htime >> LAMP_DIV8_SHIFT;
    end else begin
      lamp_time = lamp3_prod[RECIP3_PW-1:RECIP3_SHIFT];
    end
  end

  // timers and drive flags
  always_ff @(posedge clk) begin
    if (rst) begin
      heat_left <= '0;
      lamp_left <= '0;
      warm      <= 1'b0;
      plug_drv  <= 1'b0;
      lamp_drv  <= 1'b0;
    end else begin
      if (cmd.eval) begin
        warm <= warm_new;
      end
      if (cmd.apply) begin
        if (item_run) begin
          heat_left <= $signed({1'b0, run_sat});
          if (htime_nz) begin
            plug_drv <= 1'b1;
            warm     <= 1'b1;
          end
        end else begin
          heat_left <= $signed({1'b0, htime});
          if (htime_nz) begin
            plug_drv  <= 1'b1;
            lamp_drv  <= 1'b1;
            lamp_left <= $signed({1'b0, lamp_time});
          end
        end
      end
      // one-second countdown, timers park at -1
      if (cmd.tick && item_run && item_tick && !heat_left[CNT_W-1]) begin
        if (heat_left == '0) begin
          plug_drv <= 1'b0;
        end
        heat_left <= heat_left - 17'sd1;
        if (!lamp_left[CNT_W-1]) begin
          if (lamp_left == '0) begin
            lamp_drv <= 1'b0;
          end
          lamp_left <= lamp_left - 17'sd1;
        end
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (cmd.out_load) begin
      res_valid <= 1'b1;
    end else if (res_ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      plug_on <= plug_drv;
      lamp_on <= lamp_drv;
      heating <= !heat_left[CNT_W-1] && (|heat_left[CNT_W-2:0]);
    end
  end

  a_heat_park: assert property (@(posedge clk) disable iff (rst)
    heat_left[CNT_W-1] |-> (heat_left == -17'sd1))
    else $error("heat timer below its parking value");

  a_lamp_park: assert property (@(posedge clk) disable iff (rst)
    lamp_left[CNT_W-1] |-> (lamp_left == -17'sd1))
    else $error("lamp timer below its parking value");

  a_heat_needs_plug: assert property (@(posedge clk) disable iff (rst)
    (!heat_left[CNT_W-1] && (|heat_left[CNT_W-2:0])) |-> plug_drv)
    else $error("heating time left with the plug switched off");

endmodule

// ===== rtl/core/gptc_ctrl.sv =====
// ----------------------------------------------------------------------------
// gptc_ctrl
// Sequencer: accepts one request, steps the datapath through evaluation,
// division (skipped for a zero heating time) and update when heating is
// needed, then countdown, and hands the result to the output register.
// ----------------------------------------------------------------------------
module gptc_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  gptc_pkg::sts_t  sts,
  output gptc_pkg::cmd_t  cmd
);
  import gptc_pkg::*;

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_EVAL  = 3'd1;
  localparam logic [2:0] ST_DIV   = 3'd2;
  localparam logic [2:0] ST_APPLY = 3'd3;
  localparam logic [2:0] ST_TICK  = 3'd4;
  localparam logic [2:0] ST_DONE  = 3'd5;

  logic [2:0] state;
  logic [2:0] state_next;

  // next state and command decode
  always_comb begin
    cmd        = '0;
    state_next = state;
    in_ready   = (state == ST_IDLE);
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = ST_EVAL;
        end
      end
      ST_EVAL: begin
        cmd.eval = 1'b1;
        if (!sts.need_heat) begin
          state_next = ST_TICK;
        end else if (sts.zero_time) begin
          cmd.time_clear = 1'b1;
          state_next     = ST_APPLY;
        end else begin
          cmd.div_start = 1'b1;
          state_next    = ST_DIV;
        end
      end
      ST_DIV: begin
        if (sts.div_done) begin
          cmd.time_load = 1'b1;
          state_next    = ST_APPLY;
        end
      end
      ST_APPLY: begin
        cmd.apply  = 1'b1;
        state_next = ST_TICK;
      end
      ST_TICK: begin
        cmd.tick   = 1'b1;
        state_next = ST_DONE;
      end
      ST_DONE: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

// ===== rtl/core/glow_plug_timer_controller_top.sv =====
// ----------------------------------------------------------------------------
// glow_plug_timer_controller_top
// Glow plug and lamp timing for a diesel engine.
//
// Channels: req carries one beat per engine event (start or run step with
// coolant temperature, rpm and a one-second tick); res returns one beat per
// request with the plug drive, lamp drive and heating flag after that event.
// Configuration is written through cfg_wr_en / cfg_index / cfg_data; the
// user must do so only while no request is in flight, which the block
// itself does not enforce. One request is worked at a time: it is
// evaluated; a start, or a run step that arms after-start heating, below a
// non-zero minimum temperature then runs the 17-step serial divider, one at
// or above that temperature or with a zero minimum skips it; both then take
// the update. Any other run step skips divider and update. Every request
// then takes the countdown step and the result load. The next request is
// accepted at the same edge at which the result beat can first be taken,
// even if the result is still waiting on res.ready. A stalled res holds its
// beat and the sequencer waits before loading the next result. Reset (rst,
// synchronous) restores the default registers, clears both timers, the warm
// flag and both drives, and empties res.
// ----------------------------------------------------------------------------
module glow_plug_timer_controller_top (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_wr_en,
  input  logic [gptc_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [gptc_pkg::CFG_DATA_W-1:0]   cfg_data,
  gptc_req_if.sink                          req,
  gptc_res_if.source                        res
);
  import gptc_pkg::*;

  cmd_t cmd;
  sts_t sts;
  logic in_ready;

  assign req.ready = in_ready;

  // sequencer
  gptc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (req.valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // datapath
  gptc_dp u_dp (
    .clk          (clk),
    .rst          (rst),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .req_type     (req.req_type),
    .coolant_temp (req.coolant_temp),
    .engine_rpm   (req.engine_rpm),
    .second_tick  (req.second_tick),
    .res_valid    (res.valid),
    .res_ready    (res.ready),
    .plug_on      (res.plug_on),
    .lamp_on      (res.lamp_on),
    .heating      (res.heating),
    .cmd          (cmd),
    .sts          (sts)
  );

endmodule

// ===== tb/gptc_tb_pkg.sv =====
// ----------------------------------------------------------------------------
// gptc_tb_pkg
// Request codes shared by the glow plug timer controller testbench and its
// checker, and the drive beat layout that the checker uses.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
package gptc_tb_pkg;

  // request kinds on the req channel
  localparam logic REQ_START = 1'b0;
  localparam logic REQ_RUN   = 1'b1;

  // one result beat as the checker holds it
  typedef struct packed {
    logic plug_on;
    logic lamp_on;
    logic heating;
  } drive_t;

endpackage

// ===== tb/gptc_checker.sv =====
// ----------------------------------------------------------------------------
// gptc_checker
// Watches the config port and both channels of the glow plug timer
// controller, keeps its own copy of the timers, warm flag and drives, and
// compares every result beat against the predicted plug, lamp and heating
// outputs in request order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module gptc_checker (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_wr_en,
  input  logic [gptc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [gptc_pkg::CFG_DATA_W-1:0] cfg_data,
  gptc_req_if                             req,
  gptc_res_if                             res,
  output int unsigned                     errors,
  output int unsigned                     compared,
  output int unsigned                     pending
);
  import gptc_pkg::*;
  import gptc_tb_pkg::*;

  localparam int                BOOST_W   = TIME_W + MULT_W;
  localparam logic [TIME_W-1:0] SECS_CEIL = '1;

  // register copies
  logic [TMIN_W-1:0]        tmin_q;
  logic [MAXS_W-1:0]        maxs_q;
  logic signed [TEMP_W-1:0] cold_q;
  logic [RPM_W-1:0]         rpm_min_q;
  logic [MULT_W-1:0]        mult_q;

  // timer and drive state
  logic signed [CNT_W-1:0]  heat_left;
  logic signed [CNT_W-1:0]  lamp_left;
  logic                     warm;
  logic                     plug;
  logic                     lamp;

  drive_t                   drive_q[$];

  // heating seconds for a coolant temperature, zero at or above tmin
  function automatic logic [TIME_W-1:0] glow_seconds(input logic signed [TEMP_W-1:0] temp);
    logic signed [TEMP_W+1:0] span;
    logic [PROD_W-1:0]        prod;
    logic [PROD_W-1:0]        quo;
    if (tmin_q == '0 || temp >= $signed({2'b00, tmin_q})) return '0;
    span = $signed({3'b000, tmin_q}) - temp;
    prod = PROD_W'(maxs_q) * PROD_W'(span[TEMP_W:0]);
    quo  = prod / PROD_W'(tmin_q);
    return (quo > PROD_W'(SECS_CEIL)) ? SECS_CEIL : quo[TIME_W-1:0];
  endfunction

  // advance the controller by one request and return the drives after it
  function automatic drive_t step_glow(input logic                     kind,
                                       input logic signed [TEMP_W-1:0] temp,
                                       input logic [RPM_W-1:0]         rpm,
                                       input logic                     tick);
    logic [TIME_W-1:0]  secs;
    logic [BOOST_W-1:0] boosted;
    drive_t             outv;
    if (kind == REQ_START) begin
      // pre-glow: load heat time, light plug and lamp if there is any
      secs      = glow_seconds(temp);
      heat_left = CNT_W'(secs);
      if (secs != '0) begin
        plug      = 1'b1;
        lamp      = 1'b1;
        lamp_left = (temp >= LAMP_SHORT_TEMP) ? CNT_W'(secs / 8) : CNT_W'(secs / 3);
      end
    end else begin
      if (temp > cold_q) warm = 1'b1;
      // after-start heating, armed at most once
      if (!warm && rpm > rpm_min_q) begin
        secs      = glow_seconds(temp);
        heat_left = CNT_W'(secs);
        if (secs != '0) begin
          boosted   = BOOST_W'(secs) * BOOST_W'(mult_q);
          heat_left = (boosted > BOOST_W'(SECS_CEIL)) ? CNT_W'(SECS_CEIL) : CNT_W'(boosted);
          plug      = 1'b1;
          warm      = 1'b1;
        end
      end
      // one-second countdown, parked timers stay at -1
      if (tick && heat_left >= 0) begin
        if (heat_left <= 0) plug = 1'b0;
        heat_left = heat_left - 17'sd1;
        if (lamp_left >= 0) begin
          if (lamp_left <= 0) lamp = 1'b0;
          lamp_left = lamp_left - 17'sd1;
        end
      end
    end
    outv.plug_on = plug;
    outv.lamp_on = lamp;
    outv.heating = (heat_left > 0);
    return outv;
  endfunction

  task automatic check_field(input string name, input logic want, input logic got);
    if (want !== got) begin
      errors++;
      $display("%0t: %s mismatch, expected %b, actual %b", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin : watch
    drive_t want;
    if (rst) begin
      tmin_q    = RST_GLOW_MIN_TEMP;
      maxs_q    = RST_MAX_GLOW_SECONDS;
      cold_q    = RST_COLD_ENGINE_TEMP;
      rpm_min_q = RST_MIN_RUNNING_RPM;
      mult_q    = RST_AFTER_START_MULT;
      heat_left = '0;
      lamp_left = '0;
      warm      = 1'b0;
      plug      = 1'b0;
      lamp      = 1'b0;
      drive_q.delete();
    end else begin
      // register writes
      if (cfg_wr_en) begin
        case (cfg_index)
          CFG_GLOW_MIN_TEMP:    tmin_q    = cfg_data[TMIN_W-1:0];
          CFG_MAX_GLOW_SECONDS: maxs_q    = cfg_data[MAXS_W-1:0];
          CFG_COLD_ENGINE_TEMP: cold_q    = cfg_data[TEMP_W-1:0];
          CFG_MIN_RUNNING_RPM:  rpm_min_q = cfg_data[RPM_W-1:0];
          CFG_AFTER_START_MULT: mult_q    = cfg_data[MULT_W-1:0];
          default: ;
        endcase
      end
      // result beat against the oldest prediction
      if (res.valid && res.ready) begin
        if (drive_q.size() == 0) begin
          errors++;
          $display("%0t: result beat with nothing expected, expected none, actual %b%b%b",
                   $time, res.plug_on, res.lamp_on, res.heating);
        end else begin
          want = drive_q.pop_front();
          check_field("plug_on", want.plug_on, res.plug_on);
          check_field("lamp_on", want.lamp_on, res.lamp_on);
          check_field("heating", want.heating, res.heating);
          compared++;
        end
      end
      // request beat
      if (req.valid && req.ready)
        drive_q.push_back(step_glow(req.req_type, req.coolant_temp, req.engine_rpm,
                                    req.second_tick));
    end
    pending = drive_q.size();
  end

endmodule

// ===== tb/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Drives the glow plug timer controller with a directed set of start and run
// requests covering the timing corner cases, then random start/run sequences
// under several register settings and idle patterns on both channels. A
// checker beside the block predicts and compares every result beat.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module testbench;
  import gptc_pkg::*;
  import gptc_tb_pkg::*;

  localparam int PHASES      = 8;
  localparam int PHASE_BEATS = 50;
  localparam int HOLD_CYCLES = 300;
  localparam int RPM_TOP     = (1 << RPM_W) - 1;

  logic                  clk;
  logic                  rst;
  logic                  cfg_wr_en;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  int unsigned errors;
  int unsigned compared;
  int unsigned pending;
  int unsigned src_idle_pct;
  int unsigned snk_idle_pct;
  int unsigned beats_sent;
  int unsigned directed_beats;
  int unsigned settings_used;
  bit          hold_start;

  gptc_req_if req_ch ();
  gptc_res_if res_ch ();

  glow_plug_timer_controller_top i_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .req       (req_ch),
    .res       (res_ch)
  );

  gptc_checker i_checker (
    .clk       (clk),
    .rst       (rst),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .req       (req_ch),
    .res       (res_ch),
    .errors    (errors),
    .compared  (compared),
    .pending   (pending)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // watchdog
  initial begin
    #2_000_000;
    $display("watchdog expired with %0d results outstanding", pending);
    $display("TB_ERROR");
    $finish;
  end

  // result side: random back-pressure plus one long hold-off
  initial begin : sink_side
    int unsigned hold_left;
    bit          hold_used;
    hold_left = 0;
    hold_used = 1'b0;
    res_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_start && !hold_used) begin
        hold_used = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left != 0) begin
        hold_left--;
        res_ch.ready <= 1'b0;
      end else begin
        res_ch.ready <= ($urandom_range(99) >= snk_idle_pct);
      end
    end
  end

  // offer one request beat, valid stays high after the accept
  task automatic send_item(input logic                     kind,
                           input logic signed [TEMP_W-1:0] temp,
                           input logic [RPM_W-1:0]         rpm,
                           input logic                     tick);
    if ($urandom_range(99) < src_idle_pct) begin
      req_ch.valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < src_idle_pct);
    end
    req_ch.valid        <= 1'b1;
    req_ch.req_type     <= kind;
    req_ch.coolant_temp <= temp;
    req_ch.engine_rpm   <= rpm;
    req_ch.second_tick  <= tick;
    do @(posedge clk); while (!req_ch.ready);
    beats_sent++;
  endtask

  // stop offering and wait until every result has come back
  task automatic drain();
    req_ch.valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (4) @(posedge clk);
  endtask

  // write all five registers back to back
  task automatic write_setting(input logic [TMIN_W-1:0]        tmin,
                               input logic [MAXS_W-1:0]        maxs,
                               input logic signed [TEMP_W-1:0] cold,
                               input logic [RPM_W-1:0]         rpm_min,
                               input logic [MULT_W-1:0]        mult);
    cfg_wr_en <= 1'b1;
    cfg_index <= CFG_GLOW_MIN_TEMP;
    cfg_data  <= CFG_DATA_W'(tmin);
    @(posedge clk);
    cfg_index <= CFG_MAX_GLOW_SECONDS;
    cfg_data  <= CFG_DATA_W'(maxs);
    @(posedge clk);
    cfg_index <= CFG_COLD_ENGINE_TEMP;
    cfg_data  <= {{(CFG_DATA_W-TEMP_W){1'b0}}, cold};
    @(posedge clk);
    cfg_index <= CFG_MIN_RUNNING_RPM;
    cfg_data  <= CFG_DATA_W'(rpm_min);
    @(posedge clk);
    cfg_index <= CFG_AFTER_START_MULT;
    cfg_data  <= CFG_DATA_W'(mult);
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    settings_used++;
  endtask

  initial begin : stimulus
    int phase;
    int t;
    int n;
    int unsigned first_beat;

    rst                 <= 1'b1;
    cfg_wr_en           <= 1'b0;
    cfg_index           <= CFG_GLOW_MIN_TEMP;
    cfg_data            <= '0;
    req_ch.valid        <= 1'b0;
    req_ch.req_type     <= REQ_START;
    req_ch.coolant_temp <= '0;
    req_ch.engine_rpm   <= '0;
    req_ch.second_tick  <= 1'b0;
    src_idle_pct = 26;
    snk_idle_pct = 46;
    hold_start   = 1'b0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // default registers: pre-glow times, lamp divisor, expiry and parking
    send_item(REQ_START, TEMP_W'(-256), RPM_W'(0), 1'b0);
    send_item(REQ_START, TEMP_W'(4), RPM_W'(RPM_TOP), 1'b1);
    send_item(REQ_START, TEMP_W'(5), RPM_W'(0), 1'b0);
    send_item(REQ_START, TEMP_W'(255), RPM_W'(0), 1'b0);
    send_item(REQ_START, TEMP_W'(59), RPM_W'(0), 1'b0);
    send_item(REQ_START, TEMP_W'(-40), RPM_W'(0), 1'b0);
    send_item(REQ_RUN, TEMP_W'(20), RPM_W'(500), 1'b0);
    send_item(REQ_RUN, TEMP_W'(50), RPM_W'(0), 1'b1);
    send_item(REQ_START, TEMP_W'(58), RPM_W'(0), 1'b0);
    send_item(REQ_RUN, TEMP_W'(50), RPM_W'(0), 1'b1);
    send_item(REQ_RUN, TEMP_W'(50), RPM_W'(0), 1'b1);
    send_item(REQ_RUN, TEMP_W'(50), RPM_W'(0), 1'b1);

    // zero minimum temperature: no heat, after-start check clears the timer
    drain();
    write_setting(TMIN_W'(0), MAXS_W'(255), TEMP_W'(150), RPM_W'(0), MULT_W'(15));
    send_item(REQ_START, TEMP_W'(-256), RPM_W'(0), 1'b0);
    send_item(REQ_RUN, TEMP_W'(-40), RPM_W'(1), 1'b0);
    send_item(REQ_RUN, TEMP_W'(150), RPM_W'(RPM_TOP), 1'b1);

    // top register values but a zero multiplier, rpm at the running threshold
    drain();
    write_setting(TMIN_W'(127), MAXS_W'(255), TEMP_W'(255), RPM_W'(RPM_TOP), MULT_W'(0));
    send_item(REQ_START, TEMP_W'(127), RPM_W'(0), 1'b0);
    send_item(REQ_START, TEMP_W'(126), RPM_W'(0), 1'b0);
    send_item(REQ_RUN, TEMP_W'(-256), RPM_W'(RPM_TOP), 1'b1);

    // zero multiplier arms after-start with no time, next tick drops the plug
    drain();
    write_setting(TMIN_W'(100), MAXS_W'(255), TEMP_W'(-256), RPM_W'(0), MULT_W'(0));
    send_item(REQ_RUN, TEMP_W'(-256), RPM_W'(100), 1'b0);
    send_item(REQ_RUN, TEMP_W'(0), RPM_W'(0), 1'b1);
    send_item(REQ_RUN, TEMP_W'(0), RPM_W'(RPM_TOP), 1'b1);
    directed_beats = beats_sent;

    // random start/run sequences, one register setting per phase
    for (phase = 0; phase < PHASES; phase++) begin
      drain();
      if (phase < 3) begin
        src_idle_pct = 26;
        snk_idle_pct = 46;
      end else if (phase < 6) begin
        src_idle_pct = 46;
        snk_idle_pct = 26;
      end else begin
        src_idle_pct = 0;
        snk_idle_pct = 0;
      end
      if (phase == 4) hold_start = 1'b1;
      case (phase)
        0: write_setting(TMIN_W'(127), MAXS_W'(255), TEMP_W'(255), RPM_W'(RPM_TOP),
                         MULT_W'(15));
        1: write_setting(TMIN_W'(1), MAXS_W'(0), TEMP_W'(-256), RPM_W'(0), MULT_W'(1));
        default: write_setting(($urandom_range(7) == 0) ? TMIN_W'(0)
                                                        : TMIN_W'($urandom_range(1, 100)),
                               MAXS_W'($urandom_range(40)),
                               TEMP_W'(int'($urandom_range(190)) - 40),
                               RPM_W'($urandom_range(8000)),
                               MULT_W'($urandom_range(1, 15)));
      endcase
      first_beat = beats_sent;
      while (beats_sent - first_beat < PHASE_BEATS) begin
        if ($urandom_range(99) < 15) begin
          // noise: any field value
          send_item(1'($urandom_range(1)), TEMP_W'($urandom_range(511)),
                    RPM_W'($urandom_range(RPM_TOP)), 1'($urandom_range(1)));
        end else begin
          // key-on, then run steps with a slowly warming engine
          t = int'($urandom_range(190)) - 40;
          send_item(REQ_START, TEMP_W'(t), RPM_W'($urandom_range(RPM_TOP)),
                    1'($urandom_range(1)));
          n = $urandom_range(3, 16);
          repeat (n) begin
            t = t + int'($urandom_range(4));
            if (t > 255) t = 255;
            send_item(REQ_RUN, TEMP_W'(t), RPM_W'($urandom_range(RPM_TOP)),
                      ($urandom_range(99) < 70));
          end
        end
      end
    end

    drain();
    repeat (40) @(posedge clk);
    $display("covered %0d request beats (%0d directed) over %0d register settings",
             beats_sent, directed_beats, settings_used);
    $display("compared %0d result beats, %0d mismatches", compared, errors);
    if (errors == 0 && pending == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
